// ----- design/eg_pkg.sv -----
// Package for the epoch goodness scheduler: field widths, commands, entry
// states, entry record, sequencer states and entry unit opcodes.
// No dependencies.
`timescale 1ns / 1ps

package eg_pkg;

  // Field widths
  localparam int unsigned NUM_ENTRIES_DEF = 32;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned PID_W   = 5;
  localparam int unsigned STATE_W = 2;
  localparam int unsigned PRIO_W  = 8;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned GOOD_W  = 10;
  localparam int unsigned ENTRY_W = STATE_W + PRIO_W + COUNT_W + GOOD_W;

  // Commands; code 3 is ignored
  typedef enum logic [CMD_W-1:0] {
    CMD_SET     = 2'd0,
    CMD_CREATE  = 2'd1,
    CMD_RESCHED = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  // Entry states
  typedef enum logic [STATE_W-1:0] {
    PS_FREE  = 2'd0,
    PS_READY = 2'd1,
    PS_CURR  = 2'd2,
    PS_WAIT  = 2'd3
  } pstate_e;

  // One table entry as stored in the RAM
  typedef struct packed {
    pstate_e              state;
    logic [PRIO_W-1:0]    prio;
    logic [COUNT_W-1:0]   counter;
    logic [GOOD_W-1:0]    goodness;
  } entry_t;

  // Entry unit opcodes
  typedef enum logic [2:0] {
    ALU_PASS,
    ALU_SET_STATE,
    ALU_CREATE,
    ALU_STORE_REM,
    ALU_EPOCH,
    ALU_TO_READY,
    ALU_TO_CURR
  } alu_op_e;

  // Operands of the entry unit
  typedef struct packed {
    pstate_e              new_state;
    logic [PRIO_W-1:0]    prio;
    logic [COUNT_W-1:0]   rem;
    logic                 is_cur;
    logic [GOOD_W-1:0]    best_good;
  } alu_arg_t;

  // Status from the entry unit
  typedef struct packed {
    logic live;    // ready with quantum left
    logic better;  // candidate that beats the best goodness so far
  } alu_flags_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_SET_WR,
    S_CUR_WR,
    S_EP_SCAN,
    S_EP_UPD,
    S_PICK,
    S_FIN_CUR,
    S_FIN_NX,
    S_EMIT
  } seq_e;

endpackage

// ----- design/eg_in_if.sv -----
// Input channel of the epoch goodness scheduler: valid/ready plus command.
// Depends on eg_pkg.
`timescale 1ns / 1ps

interface eg_in_if;
  logic                      valid;
  logic                      ready;
  logic [eg_pkg::CMD_W-1:0]   cmd;
  logic [eg_pkg::PID_W-1:0]   pid;
  logic [eg_pkg::STATE_W-1:0] new_state;
  logic [eg_pkg::PRIO_W-1:0]  priority_req;
  logic [eg_pkg::COUNT_W-1:0] remaining;

  modport source (output valid, cmd, pid, new_state, priority_req, remaining,
                  input ready);
  modport sink   (input valid, cmd, pid, new_state, priority_req, remaining,
                  output ready);
endinterface

// ----- design/eg_out_if.sv -----
// Result channel of the epoch goodness scheduler: valid/ready plus result.
// Depends on eg_pkg.
`timescale 1ns / 1ps

interface eg_out_if;
  logic                      valid;
  logic                      ready;
  logic [eg_pkg::PID_W-1:0]   run_pid;
  logic                      switched;
  logic [eg_pkg::COUNT_W-1:0] quantum;

  modport source (output valid, run_pid, switched, quantum, input ready);
  modport sink   (input valid, run_pid, switched, quantum, output ready);
endinterface

// ----- design/epoch_goodness_scheduler.sv -----
// Top level of the epoch goodness scheduler: sequencer, entry table and valid bits.
// Depends on eg_pkg, eg_in_if, eg_out_if, eg_ram and eg_alu.
`timescale 1ns / 1ps

// One transaction in, one result out. The table sits in a single RAM with
// one read and one write port, walked one entry per cycle by a sequencer
// around a shared entry unit; the block takes no new transaction while it
// works. A reschedule steps the read port through the table for the epoch
// check, then for the epoch update when a new epoch starts, and then for the
// pick, which is skipped when the running entry keeps the processor at the
// end of an epoch. The output register lets a new transaction be taken while
// a result waits. Entries carry valid bits cleared at reset, so no clearing
// pass is needed.
module epoch_goodness_scheduler #(
  parameter int unsigned NUM_ENTRIES = eg_pkg::NUM_ENTRIES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  eg_in_if.sink           in_i,
  eg_out_if.source        out_o
);

  localparam int unsigned IDX_W  = $clog2(NUM_ENTRIES);
  localparam int unsigned IDXC_W = $clog2(NUM_ENTRIES + 1);

  eg_pkg::seq_e state_q, state_d;

  // Control registers
  logic [IDX_W-1:0]       cur_q, cur_d;
  logic [NUM_ENTRIES-1:0] valid_q, valid_d;
  logic                   rd_valid_q;
  logic [IDXC_W-1:0]      idx_q, idx_d;
  logic                   pend_q, pend_d;
  logic                   live_q, live_d;
  logic                   out_valid_q, out_valid_d;

  // Payload registers
  logic [eg_pkg::PID_W-1:0]   pid_q, pid_d;
  eg_pkg::pstate_e            nst_q, nst_d;
  logic [eg_pkg::PRIO_W-1:0]  prio_q, prio_d;
  logic [eg_pkg::COUNT_W-1:0] rem_q, rem_d;
  logic [IDX_W-1:0]           paddr_q, paddr_d;
  logic [IDX_W-1:0]           best_q, best_d;
  logic [eg_pkg::GOOD_W-1:0]  bestg_q, bestg_d;
  logic [eg_pkg::COUNT_W-1:0] curc_q, curc_d;
  eg_pkg::pstate_e            curst_q, curst_d;
  logic                       res_sw_q, res_sw_d;
  logic [eg_pkg::COUNT_W-1:0] res_quant_q, res_quant_d;
  logic [eg_pkg::PID_W-1:0]   out_pid_q, out_pid_d;
  logic                       out_sw_q, out_sw_d;
  logic [eg_pkg::COUNT_W-1:0] out_quant_q, out_quant_d;

  // RAM and entry unit wiring
  logic                       ram_we;
  logic [IDX_W-1:0]           ram_waddr, ram_raddr;
  logic [eg_pkg::ENTRY_W-1:0] ram_rdata;
  eg_pkg::entry_t             rd_ent, alu_ent;
  eg_pkg::alu_op_e            alu_op;
  eg_pkg::alu_arg_t           alu_arg;
  eg_pkg::alu_flags_t         alu_flags;

  logic                       in_acc, pid_ok, scan_issue, scan_done;
  eg_pkg::cmd_e               in_cmd;

  assign in_cmd = eg_pkg::cmd_e'(in_i.cmd);
  assign in_acc = in_i.valid && in_i.ready;
  assign pid_ok = 32'(in_i.pid) < NUM_ENTRIES;

  // Entries never written read as the reset record
  assign rd_ent = rd_valid_q ? eg_pkg::entry_t'(ram_rdata) : '0;

  eg_ram #(
    .WIDTH (eg_pkg::ENTRY_W),
    .DEPTH (NUM_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (alu_ent),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Operands come straight from the port while idle, else from latched fields
  always_comb begin
    if (state_q == eg_pkg::S_IDLE) begin
      alu_arg.new_state = eg_pkg::pstate_e'(in_i.new_state);
      alu_arg.prio      = in_i.priority_req;
      alu_arg.rem       = in_i.remaining;
    end else begin
      alu_arg.new_state = nst_q;
      alu_arg.prio      = prio_q;
      alu_arg.rem       = rem_q;
    end
    alu_arg.is_cur    = (paddr_q == cur_q);
    alu_arg.best_good = bestg_q;
  end

  eg_alu u_alu (
    .op_i    (alu_op),
    .ent_i   (rd_ent),
    .arg_i   (alu_arg),
    .ent_o   (alu_ent),
    .flags_o (alu_flags)
  );

  // Table walk: issue one read a cycle, process it the cycle after
  assign scan_issue = idx_q < IDXC_W'(NUM_ENTRIES);
  assign scan_done  = !scan_issue && !pend_q;

  // Sequencer: next state and datapath control
  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    valid_d     = valid_q;
    idx_d       = idx_q;
    pend_d      = 1'b0;
    live_d      = live_q;
    out_valid_d = out_valid_q && !out_o.ready;
    pid_d       = pid_q;
    nst_d       = nst_q;
    prio_d      = prio_q;
    rem_d       = rem_q;
    paddr_d     = paddr_q;
    best_d      = best_q;
    bestg_d     = bestg_q;
    curc_d      = curc_q;
    curst_d     = curst_q;
    res_sw_d    = res_sw_q;
    res_quant_d = res_quant_q;
    out_pid_d   = out_pid_q;
    out_sw_d    = out_sw_q;
    out_quant_d = out_quant_q;
    ram_we      = 1'b0;
    ram_waddr   = paddr_q;
    ram_raddr   = idx_q[IDX_W-1:0];
    alu_op      = eg_pkg::ALU_PASS;

    unique case (state_q)
      eg_pkg::S_IDLE: begin
        ram_raddr = (in_cmd == eg_pkg::CMD_RESCHED) ? cur_q : IDX_W'(in_i.pid);
        alu_op    = eg_pkg::ALU_CREATE;
        if (in_acc) begin
          pid_d       = in_i.pid;
          nst_d       = eg_pkg::pstate_e'(in_i.new_state);
          prio_d      = in_i.priority_req;
          rem_d       = in_i.remaining;
          res_sw_d    = 1'b0;
          res_quant_d = '0;
          unique case (in_cmd)
            eg_pkg::CMD_SET: begin
              state_d = pid_ok ? eg_pkg::S_SET_WR : eg_pkg::S_EMIT;
            end
            eg_pkg::CMD_CREATE: begin
              if (pid_ok) begin
                ram_we    = 1'b1;
                ram_waddr = IDX_W'(in_i.pid);
              end
              state_d = eg_pkg::S_EMIT;
            end
            eg_pkg::CMD_RESCHED: state_d = eg_pkg::S_CUR_WR;
            eg_pkg::CMD_NONE:    state_d = eg_pkg::S_EMIT;
            default:             state_d = eg_pkg::S_EMIT;
          endcase
        end
      end

      // Set state: write back the entry read in the accept cycle
      eg_pkg::S_SET_WR: begin
        alu_op    = eg_pkg::ALU_SET_STATE;
        ram_we    = 1'b1;
        ram_waddr = IDX_W'(pid_q);
        state_d   = eg_pkg::S_EMIT;
      end

      // Reschedule: store remaining quantum into the running entry
      eg_pkg::S_CUR_WR: begin
        alu_op    = eg_pkg::ALU_STORE_REM;
        ram_we    = 1'b1;
        ram_waddr = cur_q;
        curst_d   = rd_ent.state;
        idx_d     = '0;
        live_d    = 1'b0;
        state_d   = eg_pkg::S_EP_SCAN;
      end

      // Look for a ready entry with quantum left
      eg_pkg::S_EP_SCAN: begin
        pend_d  = scan_issue;
        paddr_d = idx_q[IDX_W-1:0];
        if (scan_issue) begin
          idx_d = idx_q + 1'b1;
        end
        if (pend_q && alu_flags.live) begin
          live_d = 1'b1;
        end
        if (scan_done) begin
          idx_d = '0;
          if (live_q) begin
            best_d  = '0;
            bestg_d = '0;
            state_d = eg_pkg::S_PICK;
          end else if (curst_q == eg_pkg::PS_CURR && rem_q != '0) begin
            // Epoch over but the running entry keeps the processor
            res_quant_d = rem_q;
            state_d     = eg_pkg::S_EMIT;
          end else begin
            state_d = eg_pkg::S_EP_UPD;
          end
        end
      end

      // New epoch: recompute goodness and counter of every entry that is not free
      eg_pkg::S_EP_UPD: begin
        alu_op  = eg_pkg::ALU_EPOCH;
        pend_d  = scan_issue;
        paddr_d = idx_q[IDX_W-1:0];
        if (scan_issue) begin
          idx_d = idx_q + 1'b1;
        end
        if (pend_q) begin
          ram_we = 1'b1;
        end
        if (scan_done) begin
          idx_d   = '0;
          best_d  = '0;
          bestg_d = '0;
          state_d = eg_pkg::S_PICK;
        end
      end

      // Pick the highest goodness, lowest index on ties
      eg_pkg::S_PICK: begin
        pend_d  = scan_issue;
        paddr_d = idx_q[IDX_W-1:0];
        if (scan_issue) begin
          idx_d = idx_q + 1'b1;
        end
        if (pend_q) begin
          if (alu_flags.better) begin
            best_d  = paddr_q;
            bestg_d = rd_ent.goodness;
          end
          if (paddr_q == cur_q) begin
            curc_d = rd_ent.counter;
          end
        end
        if (scan_done) begin
          if (best_q == cur_q && curst_q == eg_pkg::PS_CURR) begin
            res_quant_d = curc_q;
            state_d     = eg_pkg::S_EMIT;
          end else if (curst_q == eg_pkg::PS_CURR) begin
            ram_raddr = cur_q;
            state_d   = eg_pkg::S_FIN_CUR;
          end else begin
            ram_raddr = best_q;
            state_d   = eg_pkg::S_FIN_NX;
          end
        end
      end

      // Demote the old running entry, fetch the new one
      eg_pkg::S_FIN_CUR: begin
        alu_op    = eg_pkg::ALU_TO_READY;
        ram_we    = 1'b1;
        ram_waddr = cur_q;
        ram_raddr = best_q;
        state_d   = eg_pkg::S_FIN_NX;
      end

      // Promote the picked entry and grant its quantum
      eg_pkg::S_FIN_NX: begin
        alu_op      = eg_pkg::ALU_TO_CURR;
        ram_we      = 1'b1;
        ram_waddr   = best_q;
        cur_d       = best_q;
        res_sw_d    = (best_q != cur_q);
        res_quant_d = (best_q == '0) ? eg_pkg::COUNT_W'(1) : rd_ent.counter;
        state_d     = eg_pkg::S_EMIT;
      end

      // Hand the result to the output register once it is free
      eg_pkg::S_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_pid_d   = eg_pkg::PID_W'(cur_q);
          out_sw_d    = res_sw_q;
          out_quant_d = res_quant_q;
          state_d     = eg_pkg::S_IDLE;
        end
      end

      default: state_d = eg_pkg::S_IDLE;
    endcase

    if (ram_we) begin
      valid_d[ram_waddr] = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= eg_pkg::S_IDLE;
      cur_q       <= '0;
      valid_q     <= '0;
      rd_valid_q  <= 1'b0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      live_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      valid_q     <= valid_d;
      rd_valid_q  <= valid_q[ram_raddr];
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      live_q      <= live_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    pid_q       <= pid_d;
    nst_q       <= nst_d;
    prio_q      <= prio_d;
    rem_q       <= rem_d;
    paddr_q     <= paddr_d;
    best_q      <= best_d;
    bestg_q     <= bestg_d;
    curc_q      <= curc_d;
    curst_q     <= curst_d;
    res_sw_q    <= res_sw_d;
    res_quant_q <= res_quant_d;
    out_pid_q   <= out_pid_d;
    out_sw_q    <= out_sw_d;
    out_quant_q <= out_quant_d;
  end

  assign in_i.ready     = (state_q == eg_pkg::S_IDLE);
  assign out_o.valid    = out_valid_q;
  assign out_o.run_pid  = out_pid_q;
  assign out_o.switched = out_sw_q;
  assign out_o.quantum  = out_quant_q;

  // Leaving the emit state always leaves a result in the output register
  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == eg_pkg::S_EMIT && state_d == eg_pkg::S_IDLE) |=> out_valid_q)
    else $error("emit left without loading the output register");

  // Valid bits are only ever set
  a_valid_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ((valid_q & $past(valid_q)) == $past(valid_q)))
    else $error("table valid bit cleared");

  // Best goodness never drops during the pick walk
  a_pick_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == eg_pkg::S_PICK && $past(state_q) == eg_pkg::S_PICK)
      |-> (bestg_q >= $past(bestg_q)))
    else $error("best goodness decreased during pick");

  // The running id only changes when a switch completes
  a_cur_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_q != $past(cur_q)) |-> ($past(state_q) == eg_pkg::S_FIN_NX))
    else $error("running id changed outside a switch");

endmodule

// ----- design/eg_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module eg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- design/eg_alu.sv -----
// Shared entry unit: computes the updated entry record and scan flags for
// one table entry per cycle. Depends on eg_pkg.
`timescale 1ns / 1ps

module eg_alu (
  input  eg_pkg::alu_op_e    op_i,
  input  eg_pkg::entry_t     ent_i,
  input  eg_pkg::alu_arg_t   arg_i,
  output eg_pkg::entry_t     ent_o,
  output eg_pkg::alu_flags_t flags_o
);

  logic cand;

  // Entry update
  always_comb begin
    ent_o = ent_i;
    unique case (op_i)
      eg_pkg::ALU_PASS: ;
      eg_pkg::ALU_SET_STATE: ent_o.state = arg_i.new_state;
      eg_pkg::ALU_CREATE: begin
        ent_o.state    = eg_pkg::PS_READY;
        ent_o.prio     = arg_i.prio;
        ent_o.counter  = '0;
        ent_o.goodness = '0;
      end
      eg_pkg::ALU_STORE_REM: begin
        ent_o.counter = arg_i.rem;
        if (arg_i.rem == '0) begin
          ent_o.goodness = '0;
        end
      end
      eg_pkg::ALU_EPOCH: begin
        // goodness = prio + counter, counter = prio + counter/2; neither overflows
        if (ent_i.state != eg_pkg::PS_FREE) begin
          ent_o.goodness = eg_pkg::GOOD_W'(ent_i.prio) + eg_pkg::GOOD_W'(ent_i.counter);
          ent_o.counter  = eg_pkg::COUNT_W'(ent_i.prio) + (ent_i.counter >> 1);
        end
      end
      eg_pkg::ALU_TO_READY: ent_o.state = eg_pkg::PS_READY;
      eg_pkg::ALU_TO_CURR:  ent_o.state = eg_pkg::PS_CURR;
      default: ;
    endcase
  end

  // Scan flags
  assign cand = (ent_i.state == eg_pkg::PS_READY) ||
                (arg_i.is_cur && ent_i.state == eg_pkg::PS_CURR);
  assign flags_o.live   = (ent_i.state == eg_pkg::PS_READY) && (ent_i.counter != '0);
  assign flags_o.better = cand && (ent_i.goodness > arg_i.best_good);

endmodule
